>>> rtl/core/cbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cylinder versus box hit test.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Operand width of the shared multiplier and width of its accumulator.
  localparam int unsigned MulW = 33;
  localparam int unsigned AccW = 128;

  // Position of a partial product in the accumulator, in 32-bit steps.
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;
  localparam logic [1:0] SH_96 = 2'd3;

  // Actions of an input transaction.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // One operation of the multiply-accumulate unit.
  typedef struct packed {
    logic            en;
    logic            clear;
    logic            neg;
    logic [1:0]      shift;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mac_op_t;

  // Magnitude of a 33-bit signed difference.
  function automatic logic [MulW-1:0] mag33(input logic [MulW-1:0] v);
    logic [MulW-1:0] r;
    r = v[MulW-1] ? (~v + {{(MulW-1){1'b0}}, 1'b1}) : v;
    return r;
  endfunction

endpackage

>>> rtl/core/cylinder_box_collision_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_box_collision_test_core
// Tests a vertical cylinder against the footprint quad and height range of a
// box, in Q16.16 fixed point with exact wide products.
// ----------------------------------------------------------------------------
// Usage: the input channel carries load and test transactions. A load
// (action 0) stores one box vertex and gives no result. A test (action 1)
// gives one result transaction carrying hit.
// A test runs on one shared 33x33 multiply-accumulate unit under a sequencer:
// the height check and radius square, then per quad edge the difference,
// corner distance and cross product, a decision state, the edge distance
// compare when exactly one edge is outside and its cross product fits in 64
// bits, and the output state. A height miss or a corner hit ends it sooner.
// in_ready is low while a test runs. The finished result sits in an output
// register; a stalled receiver holds the sequencer in its final state while
// loads are not accepted.
// Reset restores radius 1.0 and height 2.0 and clears the box to zero.
// The configuration channel is always ready.
// ----------------------------------------------------------------------------
module cylinder_box_collision_test_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [2:0]  in_vertex_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HGT  = 4'd1;
  localparam logic [3:0] S_R2   = 4'd2;
  localparam logic [3:0] S_DIF  = 4'd3;
  localparam logic [3:0] S_CRN  = 4'd4;
  localparam logic [3:0] S_CCHK = 4'd5;
  localparam logic [3:0] S_CRS  = 4'd6;
  localparam logic [3:0] S_XCHK = 4'd7;
  localparam logic [3:0] S_DEC  = 4'd8;
  localparam logic [3:0] S_LEN  = 4'd9;
  localparam logic [3:0] S_LENS = 4'd10;
  localparam logic [3:0] S_RHS  = 4'd11;
  localparam logic [3:0] S_LHS  = 4'd12;
  localparam logic [3:0] S_CMP  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  localparam int unsigned W = cbc_pkg::MulW;

  // Configuration and box store.
  logic [30:0]        radius_r;
  logic [30:0]        height_r;
  logic signed [31:0] cx_r [4];
  logic signed [31:0] cz_r [4];
  logic signed [31:0] bottom_r;
  logic signed [31:0] top_r;

  // Test working registers.
  logic [3:0]         state_r, state_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [1:0]         edge_r;
  logic [1:0]         out_cnt_r;
  logic               hit_r, hit_nxt;
  logic               out_hit_r;
  logic               out_valid_r;
  logic signed [31:0] ax_r, ay_r, az_r;
  logic signed [31:0] wx_r [4];
  logic signed [31:0] wz_r [4];
  logic [W-1:0]       dx_r, dz_r, ex_r, ez_r, oex_r, oez_r;
  logic [61:0]        r2_r;
  logic [66:0]        cval_r;
  logic [66:0]        len2_r;
  logic [127:0]       rhs_r;

  cbc_pkg::mac_op_t   op;
  logic [127:0]       acc;

  logic in_acc, out_acc, height_miss, corner_hit, cross_out;
  logic [32:0] hsum;
  logic [W-1:0] mdx, mdz, mex, mez, moex, moez;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_acc   = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  // Decisions taken from registered values.
  always_comb begin
    hsum        = {ay_r[31], ay_r} + {2'b00, height_r};
    height_miss = (ay_r >= top_r) || ($signed(hsum) <= $signed({bottom_r[31], bottom_r}));
    mdx         = cbc_pkg::mag33(dx_r);
    mdz         = cbc_pkg::mag33(dz_r);
    mex         = cbc_pkg::mag33(ex_r);
    mez         = cbc_pkg::mag33(ez_r);
    moex        = cbc_pkg::mag33(oex_r);
    moez        = cbc_pkg::mag33(oez_r);
    corner_hit  = (mdx[W-1:W-2] == 2'b00) && (mdz[W-1:W-2] == 2'b00) &&
                  (acc < {66'd0, r2_r});
    cross_out   = !acc[127] && (acc != '0);
  end

  // Operand selection for the shared unit.
  always_comb begin
    op = '0;
    unique case (state_r)
      S_R2: begin
        op = '{en: 1'b1, clear: 1'b1, neg: 1'b0, shift: cbc_pkg::SH_0,
               a: {2'b00, radius_r}, b: {2'b00, radius_r}};
      end
      S_CRN: begin
        op.en = 1'b1;
        op.clear = (k_r == 3'd0);
        op.a = (k_r == 3'd0) ? mdx : mdz;
        op.b = op.a;
      end
      S_CRS: begin
        op.en = 1'b1;
        op.clear = (k_r == 3'd0);
        if (k_r == 3'd0) begin
          op.a = mdx; op.b = mez; op.neg = dx_r[W-1] ^ ez_r[W-1];
        end else begin
          op.a = mdz; op.b = mex; op.neg = ~(dz_r[W-1] ^ ex_r[W-1]);
        end
      end
      S_LEN: begin
        op.en = 1'b1;
        op.clear = (k_r == 3'd0);
        op.a = (k_r == 3'd0) ? moex : moez;
        op.b = op.a;
      end
      S_RHS: begin
        op.en = 1'b1;
        op.clear = (k_r == 3'd0);
        op.a = (k_r < 3'd3) ? {1'b0, r2_r[31:0]} : {3'b000, r2_r[61:32]};
        unique case (k_r)
          3'd0: begin op.b = {1'b0, len2_r[31:0]};     op.shift = cbc_pkg::SH_0;  end
          3'd1: begin op.b = {1'b0, len2_r[63:32]};    op.shift = cbc_pkg::SH_32; end
          3'd2: begin op.b = {30'd0, len2_r[66:64]};   op.shift = cbc_pkg::SH_64; end
          3'd3: begin op.b = {1'b0, len2_r[31:0]};     op.shift = cbc_pkg::SH_32; end
          3'd4: begin op.b = {1'b0, len2_r[63:32]};    op.shift = cbc_pkg::SH_64; end
          default: begin op.b = {30'd0, len2_r[66:64]}; op.shift = cbc_pkg::SH_96; end
        endcase
      end
      S_LHS: begin
        op.en = 1'b1;
        op.clear = (k_r == 3'd0);
        op.a = (k_r[1] == 1'b0) ? {1'b0, cval_r[31:0]} : {1'b0, cval_r[63:32]};
        op.b = (k_r[1:0] == 2'd0 || k_r[1:0] == 2'd2) ? {1'b0, cval_r[31:0]}
                                                      : {1'b0, cval_r[63:32]};
        op.shift = (k_r[1:0] == 2'd0) ? cbc_pkg::SH_0 :
                   (k_r[1:0] == 2'd3) ? cbc_pkg::SH_64 : cbc_pkg::SH_32;
      end
      default: op = '0;
    endcase
  end

  cbc_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_action == cbc_pkg::ACT_TEST) begin
          state_nxt = S_HGT;
        end
      end
      S_HGT: begin
        if (height_miss) begin
          hit_nxt = 1'b0; state_nxt = S_FIN;
        end else begin
          state_nxt = S_R2;
        end
      end
      S_R2:  state_nxt = S_DIF;
      S_DIF: begin state_nxt = S_CRN; k_nxt = 3'd0; end
      S_CRN: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd1) state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (corner_hit) begin
          hit_nxt = 1'b1; state_nxt = S_FIN;
        end else begin
          state_nxt = S_CRS; k_nxt = 3'd0;
        end
      end
      S_CRS: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd1) state_nxt = S_XCHK;
      end
      S_XCHK: state_nxt = (edge_r == 2'd3) ? S_DEC : S_DIF;
      S_DEC: begin
        if (out_cnt_r == 2'd0) begin
          hit_nxt = 1'b1; state_nxt = S_FIN;
        end else if (out_cnt_r != 2'd1 || cval_r[66:64] != 3'd0) begin
          hit_nxt = 1'b0; state_nxt = S_FIN;
        end else begin
          state_nxt = S_LEN; k_nxt = 3'd0;
        end
      end
      S_LEN: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd1) state_nxt = S_LENS;
      end
      S_LENS: begin state_nxt = S_RHS; k_nxt = 3'd0; end
      S_RHS: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd5) begin state_nxt = S_LHS; k_nxt = 3'd0; end
      end
      S_LHS: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd3) state_nxt = S_CMP;
      end
      S_CMP: begin hit_nxt = (acc < rhs_r); state_nxt = S_FIN; end
      S_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
      edge_r      <= 2'd0;
      out_cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_HGT) begin
        edge_r    <= 2'd0;
        out_cnt_r <= 2'd0;
      end else if (state_r == S_XCHK) begin
        edge_r <= edge_r + 2'd1;
        if (cross_out && out_cnt_r != 2'd2) out_cnt_r <= out_cnt_r + 2'd1;
      end
    end
  end

  // Working decision and the output register that holds it until taken.
  always_ff @(posedge clk) begin
    if (state_r != S_FIN) begin
      hit_r <= hit_nxt;
    end
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_hit_r <= hit_r;
    end
  end

  // Configuration and box store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 31'd65536;
      height_r <= 31'd131072;
      bottom_r <= '0;
      top_r    <= '0;
      for (int i = 0; i < 4; i++) begin
        cx_r[i] <= '0;
        cz_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cbc_pkg::CFG_RADIUS) radius_r <= cfg_data[30:0];
        if (cfg_index == cbc_pkg::CFG_HEIGHT) height_r <= cfg_data[30:0];
      end
      if (in_acc && in_action == cbc_pkg::ACT_LOAD) begin
        if (in_vertex_index[2] == 1'b0) begin
          cx_r[in_vertex_index[1:0]] <= in_coord_x;
          cz_r[in_vertex_index[1:0]] <= in_coord_z;
        end
        if (in_vertex_index == 3'd0) bottom_r <= in_coord_y;
        if (in_vertex_index == 3'd7) top_r    <= in_coord_y;
      end
    end
  end

  // Test payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= in_coord_x;
      ay_r <= in_coord_y;
      az_r <= in_coord_z;
    end
    // Working copy of the corners rotates one place per edge.
    if (state_r == S_HGT) begin
      for (int i = 0; i < 4; i++) begin
        wx_r[i] <= cx_r[i];
        wz_r[i] <= cz_r[i];
      end
    end else if (state_r == S_XCHK) begin
      for (int i = 0; i < 4; i++) begin
        wx_r[i] <= wx_r[(i + 1) % 4];
        wz_r[i] <= wz_r[(i + 1) % 4];
      end
    end
    if (state_r == S_DIF) begin
      dx_r <= {ax_r[31], ax_r} - {wx_r[0][31], wx_r[0]};
      dz_r <= {az_r[31], az_r} - {wz_r[0][31], wz_r[0]};
      ex_r <= {wx_r[1][31], wx_r[1]} - {wx_r[0][31], wx_r[0]};
      ez_r <= {wz_r[1][31], wz_r[1]} - {wz_r[0][31], wz_r[0]};
      if (edge_r == 2'd0) r2_r <= acc[61:0];
    end
    if (state_r == S_XCHK && cross_out) begin
      cval_r <= acc[66:0];
      oex_r  <= ex_r;
      oez_r  <= ez_r;
    end
    if (state_r == S_LENS) len2_r <= acc[66:0];
    if (state_r == S_LHS && k_r == 3'd0) rhs_r <= acc;
  end

`ifndef SYNTH
  a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == cbc_pkg::ACT_TEST |=> state_r == S_HGT)
    else $error("test transaction did not start the sequencer");
  a_rhs_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RHS |-> k_r <= 3'd5)
    else $error("partial product counter out of range");
  a_single_edge: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEN |-> out_cnt_r == 2'd1)
    else $error("edge distance test without exactly one outside edge");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_hit_r))
    else $error("pending result changed before it was taken");
`endif

endmodule

>>> rtl/core/cbc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_mac
// Shared multiply-accumulate unit: one unsigned 33x33 product per cycle,
// placed at a 32-bit step, optionally negated, added into (or, on clear, loaded into) a 128-bit register.
// ----------------------------------------------------------------------------
module cbc_mac (
  input  logic                        clk,
  input  cbc_pkg::mac_op_t            op,
  output logic [cbc_pkg::AccW-1:0]    acc
);

  logic [2*cbc_pkg::MulW-1:0] prod;
  logic [cbc_pkg::AccW-1:0]   ext;
  logic [cbc_pkg::AccW-1:0]   term;
  logic [cbc_pkg::AccW-1:0]   acc_r;
  logic [cbc_pkg::AccW-1:0]   acc_nxt;

  // Product and its placement in the wide word.
  always_comb begin
    prod = op.a * op.b;
    ext  = {{(cbc_pkg::AccW-2*cbc_pkg::MulW){1'b0}}, prod};
    unique case (op.shift)
      cbc_pkg::SH_0:  term = ext;
      cbc_pkg::SH_32: term = ext << 32;
      cbc_pkg::SH_64: term = ext << 64;
      cbc_pkg::SH_96: term = ext << 96;
      default:        term = ext;
    endcase
    if (op.neg) begin
      term = ~term + {{(cbc_pkg::AccW-1){1'b0}}, 1'b1};
    end
    acc_nxt = (op.clear ? '0 : acc_r) + term;
  end

  // Accumulator.
  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
